// ----- hw/rtl/seven_segment_scan_serializer_macros.svh -----
// assertion macros for the seven-segment scan serializer checker
// no dependencies; expects clk and rst to be visible where used
`ifndef SEVEN_SEGMENT_SCAN_SERIALIZER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_SERIALIZER_MACROS_SVH

// implication checked in the same cycle, ignored while in reset
`define SSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sss checker: same-cycle property failed");

// implication checked in the next cycle, ignored while in reset
`define SSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sss checker: next-cycle property failed");

`endif

// ----- hw/rtl/sss_pkg.sv -----
// shared types, constants and lookup functions of the scan serializer
// no dependencies
package sss_pkg;

  localparam int NUM_DIGITS   = 4;
  localparam int POS_W        = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int VALUE_W      = 14;
  localparam int PATTERN_W    = 8;
  localparam int ENABLE_W     = 4;
  localparam int BIT_CNT_W    = $clog2(PATTERN_W);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RECIP_W      = 14;
  localparam int SHIFT_W      = 5;

  localparam logic [VALUE_W-1:0]  SHOWN_MODULUS = VALUE_W'(10000);
  localparam logic [RECIP_W-1:0]  RECIP_TEN     = RECIP_W'(6554);
  localparam int                  RECIP_TEN_SH  = 16;
  localparam logic [VALUE_W-1:0]  TEN           = VALUE_W'(10);

  // one decoded digit, ready to be shifted out
  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [ENABLE_W-1:0]  enable_n;
  } cmd_t;

  // multiply-and-shift that stands in for a divide by a power of ten
  typedef struct packed {
    logic [RECIP_W-1:0] k;
    logic [SHIFT_W-1:0] sh;
  } recip_t;

  function automatic recip_t decade_recip(input logic [POS_W-1:0] pos);
    recip_t r;
    unique case (int'(pos))
      0:       begin r.k = RECIP_W'(1);    r.sh = SHIFT_W'(0);  end
      1:       begin r.k = RECIP_W'(6554); r.sh = SHIFT_W'(16); end
      2:       begin r.k = RECIP_W'(5243); r.sh = SHIFT_W'(19); end
      3:       begin r.k = RECIP_W'(8389); r.sh = SHIFT_W'(23); end
      // digits above the thousands are always zero
      default: begin r.k = RECIP_W'(0);    r.sh = SHIFT_W'(0);  end
    endcase
    return r;
  endfunction

  function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [PATTERN_W-1:0] p;
    unique case (digit)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h0C;
      4'd2:    p = 8'hB6;
      4'd3:    p = 8'h9E;
      4'd4:    p = 8'hCC;
      4'd5:    p = 8'hDA;
      4'd6:    p = 8'hFA;
      4'd7:    p = 8'h0E;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hDE;
      default: p = 8'h7E;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/sss_queue.sv -----
// two-entry command queue between digit decode and the shifter
// depends on sss_pkg
module sss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sss_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output sss_pkg::cmd_t rd_data
);

  sss_pkg::cmd_t                    entries [sss_pkg::QUEUE_DEPTH];
  logic [sss_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sss_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sss_pkg::QCNT_W-1:0]       count;
  logic                             do_wr;
  logic                             do_rd;

  assign wr_ready = (count != sss_pkg::QCNT_W'(sss_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == sss_pkg::QPTR_W'(sss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == sss_pkg::QPTR_W'(sss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/sss_front.sv -----
// front end: accepts values, tracks the scan position and decodes one digit
// depends on sss_pkg
module sss_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [sss_pkg::VALUE_W-1:0]   display_value,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output sss_pkg::cmd_t                 cmd
);

  logic                                         s1_valid, s2_valid, s3_valid;
  logic [sss_pkg::VALUE_W-1:0]                  s1_value;
  logic [sss_pkg::POS_W-1:0]                    s1_pos, s2_pos, s3_pos;
  logic [sss_pkg::VALUE_W-1:0]                  s2_quot;
  logic [sss_pkg::VALUE_W-1:0]                  s3_quot;
  logic [sss_pkg::POS_W-1:0]                    scan_position;
  logic                                         adv;
  logic                                         accept;
  logic [sss_pkg::VALUE_W-1:0]                  value_mod;
  sss_pkg::recip_t                              recip;
  logic [sss_pkg::VALUE_W+sss_pkg::RECIP_W-1:0] quot_prod;
  logic [sss_pkg::VALUE_W+sss_pkg::RECIP_W-1:0] quot_shift;
  logic [sss_pkg::VALUE_W+sss_pkg::RECIP_W-1:0] tens_prod;
  logic [sss_pkg::VALUE_W-1:0]                  tens;
  logic [sss_pkg::VALUE_W-1:0]                  rem;

  // the whole pipe moves unless the decoded digit is stuck at the queue
  assign adv    = !s3_valid || cmd_ready;
  assign full   = s1_valid && !adv;
  assign accept = push && !full;

  // stage 1: value below 16384 needs one subtract to land below 10000
  assign value_mod = (display_value >= sss_pkg::SHOWN_MODULUS)
                   ? display_value - sss_pkg::SHOWN_MODULUS : display_value;

  // stage 2: divide by the power of ten of the scanned digit
  assign recip      = sss_pkg::decade_recip(s1_pos);
  assign quot_prod  = s1_value * recip.k;
  assign quot_shift = quot_prod >> recip.sh;

  // stage 3: remainder by ten of the quotient
  assign tens_prod = s3_quot * sss_pkg::RECIP_TEN;
  assign tens      = sss_pkg::VALUE_W'(tens_prod >> sss_pkg::RECIP_TEN_SH);
  assign rem       = s3_quot - tens * sss_pkg::TEN;

  assign cmd_valid    = s3_valid;
  assign cmd.pattern  = sss_pkg::seg_pattern(rem[3:0]);
  assign cmd.enable_n = ~(sss_pkg::ENABLE_W'(1) << s3_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      scan_position <= '0;
    end else begin
      if (adv) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end else if (accept) begin
        s1_valid <= 1'b1;
      end
      if (accept) begin
        scan_position <= (scan_position == sss_pkg::POS_W'(sss_pkg::NUM_DIGITS - 1))
                       ? '0 : scan_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value <= value_mod;
      s1_pos   <= scan_position;
    end
    if (adv) begin
      s2_quot <= quot_shift[sss_pkg::VALUE_W-1:0];
      s2_pos  <= s1_pos;
      s3_quot <= s2_quot;
      s3_pos  <= s2_pos;
    end
  end

endmodule

// ----- hw/rtl/sss_back.sv -----
// back end: shifts one segment pattern out a bit per result, marks the last bit
// depends on sss_pkg
module sss_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_take,
  input  sss_pkg::cmd_t                  cmd,
  output logic                           empty,
  input  logic                           pop,
  output logic                           serial_data,
  output logic [sss_pkg::ENABLE_W-1:0]   digit_enable_n,
  output logic                           latch_last
);

  logic                             busy;
  logic [sss_pkg::BIT_CNT_W-1:0]    bit_cnt;
  logic [sss_pkg::PATTERN_W-1:0]    shreg;
  logic [sss_pkg::ENABLE_W-1:0]     enable_n;
  logic                             last_bit;
  logic                             reload;

  assign last_bit = (bit_cnt == sss_pkg::BIT_CNT_W'(sss_pkg::PATTERN_W - 1));
  assign reload   = !busy || (pop && last_bit);
  assign cmd_take = reload;

  assign empty          = !busy;
  assign serial_data    = shreg[sss_pkg::PATTERN_W-1];
  assign digit_enable_n = enable_n;
  assign latch_last     = last_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (reload) begin
      busy    <= cmd_valid;
      bit_cnt <= '0;
    end else if (pop) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (reload && cmd_valid) begin
      shreg    <= cmd.pattern;
      enable_n <= cmd.enable_n;
    end else if (busy && pop) begin
      shreg <= {shreg[sss_pkg::PATTERN_W-2:0], 1'b0};
    end
  end

endmodule

// ----- hw/rtl/seven_segment_scan_serializer.sv -----
// top level of the four-digit seven-segment scan serializer
// depends on sss_pkg, sss_front, sss_queue and sss_back
//
//   channel   handshake          payload
//   -------   ----------------   ----------------------------------------------
//   input     push / full        display_value[13:0]
//   result    empty / pop        serial_data, digit_enable_n[3:0], latch_last
//
// each accepted item yields eight results, one per cycle while pop is held;
// the shifter emits one bit per cycle while pop is held and so sets the item rate
// the first result passes through the three decode stages, the command
// queue and the shift register
// rst is synchronous and clears the scan position and all valid state
// a stalled result side fills the two-entry queue and then the decode pipe
// before full rises; the shifter holds its current bit until pop
module seven_segment_scan_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [sss_pkg::VALUE_W-1:0]   display_value,
  output logic                          empty,
  input  logic                          pop,
  output logic                          serial_data,
  output logic [sss_pkg::ENABLE_W-1:0]  digit_enable_n,
  output logic                          latch_last
);

  // decoded digit leaving the front end
  logic          f_valid;
  logic          f_ready;
  sss_pkg::cmd_t f_cmd;

  // queued digit offered to the shifter
  logic          b_valid;
  logic          b_take;
  sss_pkg::cmd_t b_cmd;

  // front end: modulo, digit select by scan position, segment lookup
  sss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .display_value (display_value),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  // short queue so decode keeps going while the shifter works
  sss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_valid),
    .rd_take  (b_take),
    .rd_data  (b_cmd)
  );

  // back end: serial bits msb first, latch mark on the eighth
  sss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (b_valid),
    .cmd_take       (b_take),
    .cmd            (b_cmd),
    .empty          (empty),
    .pop            (pop),
    .serial_data    (serial_data),
    .digit_enable_n (digit_enable_n),
    .latch_last     (latch_last)
  );

endmodule

// ----- hw/rtl/sss_checker.sv -----
// port-level checker for the scan serializer, bound to the top level
// depends on sss_pkg and seven_segment_scan_serializer_macros.svh
`include "seven_segment_scan_serializer_macros.svh"

module sss_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic                          serial_data,
  input logic [sss_pkg::ENABLE_W-1:0]  digit_enable_n,
  input logic                          latch_last
);

  logic bit_taken;
  logic stalled;
  assign bit_taken = pop && !empty;
  assign stalled   = !empty && !pop;

  // nothing waits on the result side right after reset
  `SSS_ASSERT_SAME(a_empty_after_reset, $past(rst), empty)

  // at most one digit is lit at a time
  `SSS_ASSERT_SAME(a_one_digit, !empty, $onehot0(~digit_enable_n))

  // an item's bits come back to back with the same digit select
  `SSS_ASSERT_NEXT(a_bits_contiguous, bit_taken && !latch_last, !empty && $stable(digit_enable_n))

  // a waiting result holds until it is taken
  `SSS_ASSERT_NEXT(a_result_holds, stalled, !empty && $stable(serial_data) && $stable(latch_last))

endmodule

bind seven_segment_scan_serializer sss_checker u_sss_checker (.*);
